### src/escape_rle_byte_encoder_top_defines.svh
// Assertion macros for the escape RLE byte encoder.
`ifndef ESCAPE_RLE_BYTE_ENCODER_TOP_DEFINES_SVH
`define ESCAPE_RLE_BYTE_ENCODER_TOP_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, checked on every rising edge out of reset.
`define ERLE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("escape_rle_byte_encoder: check failed");
// Next-cycle implication.
`define ERLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("escape_rle_byte_encoder: check failed");
`else
`define ERLE_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ERLE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### src/erle_pkg.sv
// Shared types and constants of the escape RLE byte encoder.
package erle_pkg;

    localparam int LIST_DEPTH = 6;   // most results one request can cause
    localparam int CNT_W      = 3;

    localparam logic [7:0] RUN_MAX       = 8'd255;
    localparam logic [7:0] MIN_CODED_RUN = 8'd3;
    localparam logic [7:0] ESCAPE_RESET  = 8'hFF;

    localparam logic [7:0] CFG_ESCAPE   = 8'd0;
    localparam logic [7:0] CFG_CAPACITY = 8'd1;

    typedef struct packed {
        logic [7:0] value;
        logic [7:0] length;
    } t_run;

    typedef struct packed {
        logic [LIST_DEPTH-1:0][7:0] bytes;
        logic [CNT_W-1:0]           count;
        logic                       fin;
        logic                       err;
    } t_plan;

endpackage

### src/escape_rle_byte_encoder_top.sv
// Escape RLE byte encoder: stream in raw bytes, stream out coded bytes.
// A taken request loads the result list; each entry then moves into the output register.
// Throughput: one result per cycle while the output is not stalled; a request is taken every cycle while it causes
// at most one result, else once its list (up to six entries) drains, so lone escape
// bytes (three results each) hold back the next request until their list drains.
// Reset (synchronous, active low) drops any open run, clears counts and flags,
// and restores escape 0xFF and full capacity.
`include "escape_rle_byte_encoder_top_defines.svh"

module escape_rle_byte_encoder_top
    import erle_pkg::*;
#(
    parameter int LENGTH_BITS = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    // Config write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [7:0]             i_cfg_index,
    input  logic [LENGTH_BITS-1:0] i_cfg_data,

    // Byte stream in
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // [7:0] data_byte
    input  logic                   s_axis_tlast,   // block_end

    // Coded stream out
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [((8+LENGTH_BITS+7)/8)*8-1:0] m_axis_tdata,
                                   // [7:0] out_byte, [8 +: LENGTH_BITS] encoded_length
    output logic                   m_axis_tlast,   // out_final
    output logic [0:0]             m_axis_tuser    // [0] overflow_error
);

    // Block state
    t_run                   r_run;
    logic [LENGTH_BITS-1:0] r_written;
    logic                   r_overflowed;
    logic [7:0]             r_escape;
    logic [LENGTH_BITS-1:0] r_capacity;

    // Pending result list of the last taken request
    logic [LIST_DEPTH-1:0][7:0] r_bytes;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_fin;
    logic                       r_err;
    logic [LENGTH_BITS-1:0]     r_len;

    // Output register
    logic                   r_out_valid;
    logic [7:0]             r_out_byte;
    logic                   r_out_fin;
    logic                   r_out_err;
    logic [LENGTH_BITS-1:0] r_out_len;

    // Planner results
    t_plan                  n_plan;
    logic [LENGTH_BITS-1:0] n_final_len;
    t_run                   n_run;
    logic [LENGTH_BITS-1:0] n_written;
    logic                   n_overflowed;

    logic in_accept;
    logic pop;
    logic last_entry;

    // Config writes are always taken; out-of-range indexes fall through.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape   <= ESCAPE_RESET;
            r_capacity <= '1;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_ESCAPE) begin
                r_escape <= i_cfg_data[7:0];
            end else if (i_cfg_index == CFG_CAPACITY) begin
                r_capacity <= i_cfg_data;
            end
        end
    end

    erle_plan #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_plan (
        .i_run        (r_run),
        .i_written    (r_written),
        .i_overflowed (r_overflowed),
        .i_escape     (r_escape),
        .i_capacity   (r_capacity),
        .i_byte       (s_axis_tdata),
        .i_last       (s_axis_tlast),
        .o_plan       (n_plan),
        .o_final_len  (n_final_len),
        .o_run        (n_run),
        .o_written    (n_written),
        .o_overflowed (n_overflowed)
    );

    // Move one list entry into the output register whenever it is free.
    assign pop        = (r_cnt != '0) && (!r_out_valid || m_axis_tready);
    assign last_entry = (r_cnt == CNT_W'(1));

    // Take a new request once the list is empty or its last entry leaves now.
    assign s_axis_tready = (r_cnt == '0) || (last_entry && pop);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run        <= '0;
            r_written    <= '0;
            r_overflowed <= 1'b0;
            r_cnt        <= '0;
        end else if (in_accept) begin
            r_run        <= n_run;
            r_written    <= n_written;
            r_overflowed <= n_overflowed;
            r_cnt        <= n_plan.count;
        end else if (pop) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // List payload: loaded whole, then shifted down one byte per pop.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_bytes <= n_plan.bytes;
            r_fin   <= n_plan.fin;
            r_err   <= n_plan.err;
            r_len   <= n_final_len;
        end else if (pop) begin
            r_bytes <= r_bytes >> 8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pop) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Final flags and length ride only on the list's last entry.
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out_byte <= r_bytes[0];
            r_out_fin  <= r_fin && last_entry;
            r_out_err  <= r_err && last_entry;
            r_out_len  <= (r_fin && last_entry) ? r_len : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_fin;
    assign m_axis_tuser  = r_out_err;

    always_comb begin
        m_axis_tdata                     = '0;
        m_axis_tdata[7:0]                = r_out_byte;
        m_axis_tdata[8 +: LENGTH_BITS]   = r_out_len;
    end

    `ERLE_ASSERT_NEXT(a_block_end_clears, i_clk, i_rst_n, in_accept && s_axis_tlast, (r_run.length == '0) && (r_written == '0) && !r_overflowed)
    `ERLE_ASSERT_NEXT(a_run_open_mid_block, i_clk, i_rst_n, in_accept && !s_axis_tlast, r_run.length != '0)
    `ERLE_ASSERT_IMPL(a_list_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CNT_W'(LIST_DEPTH))
    `ERLE_ASSERT_IMPL(a_error_result, i_clk, i_rst_n, r_out_valid && r_out_err, (r_out_byte == '0) && r_out_fin)
    `ERLE_ASSERT_IMPL(a_len_only_final, i_clk, i_rst_n, r_out_valid && !r_out_fin, r_out_len == '0)

endmodule

### src/erle_plan.sv
// Works out the result bytes and next state for one input request.
module erle_plan
    import erle_pkg::*;
#(
    parameter int LENGTH_BITS = 24
) (
    input  t_run                   i_run,
    input  logic [LENGTH_BITS-1:0] i_written,
    input  logic                   i_overflowed,
    input  logic [7:0]             i_escape,
    input  logic [LENGTH_BITS-1:0] i_capacity,
    input  logic [7:0]             i_byte,
    input  logic                   i_last,
    output t_plan                  o_plan,
    output logic [LENGTH_BITS-1:0] o_final_len,
    output t_run                   o_run,
    output logic [LENGTH_BITS-1:0] o_written,
    output logic                   o_overflowed
);

    logic               close_run;
    logic               open_new;
    t_run               cont_run;
    logic               coded_a;
    logic               coded_b;
    logic [CNT_W-1:0]   k_a;
    logic [CNT_W-1:0]   k_b;
    logic [CNT_W-1:0]   k_total;
    logic [2:0][7:0]    a_bytes;
    logic [2:0][7:0]    b_bytes;
    logic [LENGTH_BITS:0] diff;
    logic [CNT_W-1:0]   room;
    logic               over;
    logic [CNT_W-1:0]   emit_cnt;
    logic               new_ovf;
    logic               extra;
    logic [LENGTH_BITS-1:0] written_next;

    // Old run closes on a different byte or when full.
    assign close_run = (i_run.length != 8'd0) &&
                       ((i_byte != i_run.value) || (i_run.length == RUN_MAX));
    assign open_new  = (i_run.length == 8'd0) || close_run;

    always_comb begin
        cont_run.value  = open_new ? i_byte : i_run.value;
        cont_run.length = open_new ? 8'd1 : (i_run.length + 8'd1);
    end

    // Bytes of the closing run.
    assign coded_a = (i_run.length >= MIN_CODED_RUN) || (i_run.value == i_escape);
    assign k_a = !close_run ? '0 : (coded_a ? CNT_W'(3) : i_run.length[CNT_W-1:0]);
    always_comb begin
        a_bytes[0] = coded_a ? i_escape : i_run.value;
        a_bytes[1] = coded_a ? i_run.length : i_run.value;
        a_bytes[2] = i_run.value;
    end

    // Bytes of the run flushed at block end.
    assign coded_b = (cont_run.length >= MIN_CODED_RUN) || (cont_run.value == i_escape);
    assign k_b = !i_last ? '0 : (coded_b ? CNT_W'(3) : cont_run.length[CNT_W-1:0]);
    always_comb begin
        b_bytes[0] = coded_b ? i_escape : cont_run.value;
        b_bytes[1] = coded_b ? cont_run.length : cont_run.value;
        b_bytes[2] = cont_run.value;
    end

    assign k_total = k_a + k_b;

    // Room left under the capacity, saturated to what one request can use.
    assign diff = {1'b0, i_capacity} - {1'b0, i_written};
    always_comb begin
        if (i_overflowed || diff[LENGTH_BITS] || (diff == '0)) begin
            room = '0;
        end else if (diff >= (LENGTH_BITS+1)'(7)) begin
            room = CNT_W'(7);
        end else begin
            room = diff[CNT_W-1:0];
        end
    end

    assign over         = k_total > room;
    assign emit_cnt     = over ? room : k_total;
    assign new_ovf      = i_overflowed || over;
    assign written_next = i_written + LENGTH_BITS'(emit_cnt);
    assign extra        = i_last && (new_ovf || (emit_cnt == '0));

    always_comb begin
        logic [CNT_W-1:0] jj;
        logic [CNT_W-1:0] jb;
        o_plan.count = emit_cnt + CNT_W'(extra);
        o_plan.fin   = i_last;
        o_plan.err   = i_last && new_ovf;
        for (int j = 0; j < LIST_DEPTH; j++) begin
            jj = CNT_W'(j);
            jb = jj - k_a;
            if (jj >= emit_cnt) begin
                o_plan.bytes[j] = 8'd0;
            end else if (jj < k_a) begin
                o_plan.bytes[j] = a_bytes[jj[1:0]];
            end else begin
                o_plan.bytes[j] = b_bytes[jb[1:0]];
            end
        end
    end

    assign o_final_len = written_next;

    always_comb begin
        if (i_last) begin
            o_run        = '0;
            o_written    = '0;
            o_overflowed = 1'b0;
        end else begin
            o_run        = cont_run;
            o_written    = written_next;
            o_overflowed = new_ovf;
        end
    end

endmodule
